@@ sv/rlm_pkg.sv @@
// shared types and codes of the request latency monitor
package rlm_pkg;

    typedef enum logic
    {
        OP_ISSUE    = 1'b0,
        OP_COMPLETE = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_STORED    = 3'd0,
        ST_FULL      = 3'd1,
        ST_COUNTED   = 3'd2,
        ST_UNMATCHED = 3'd3,
        ST_NOGROUP   = 3'd4
    } status_t;

    typedef struct packed
    {
        op_t         op;
        logic [63:0] tag;
        logic [63:0] now;
        logic [31:0] bytes;
        logic [63:0] group;
        logic        err;
    } item_t;

    typedef struct packed
    {
        logic [63:0] tag;
        logic [63:0] start;
        logic [31:0] bytes;
        logic [63:0] group;
    } pend_t;

    typedef struct packed
    {
        logic [63:0] count;
        logic [63:0] lat_sum;
        logic [63:0] byte_sum;
        logic [63:0] err_count;
    } stats_t;

    typedef struct packed
    {
        status_t     status;
        logic [63:0] group;
        logic [63:0] latency;
        stats_t      stats;
    } result_t;

endpackage

@@ sv/rlm_ifc.sv @@
// request and result channel interfaces
interface rlm_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [63:0] request_tag;
    logic [63:0] now_time;
    logic [31:0] byte_count;
    logic [63:0] group_id;
    logic        error_flag;

    modport source (output valid, cmd, request_tag, now_time, byte_count, group_id,
                    error_flag, input ready);
    modport sink (input valid, cmd, request_tag, now_time, byte_count, group_id,
                  error_flag, output ready);
endinterface

interface rlm_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] stat_group;
    logic [63:0] latency;
    logic [63:0] group_io_count;
    logic [63:0] group_latency_sum;
    logic [63:0] group_byte_sum;
    logic [63:0] group_error_count;

    modport source (output valid, status, stat_group, latency, group_io_count,
                    group_latency_sum, group_byte_sum, group_error_count, input ready);
    modport sink (input valid, status, stat_group, latency, group_io_count,
                  group_latency_sum, group_byte_sum, group_error_count, output ready);
endinterface

@@ sv/rlm_front.sv @@
// front end: takes requests, classifies the command and queues them
module rlm_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    rlm_req_if.sink              req,
    output logic                 q_valid,
    output rlm_pkg::item_t       q_item,
    input  logic                 q_pop
);

    rlm_pkg::item_t q_reg [2];
    logic           wptr_reg;
    logic           rptr_reg;
    logic [1:0]     cnt_reg;
    logic           push;
    rlm_pkg::item_t in_item;

    // classify the incoming request
    always_comb
    begin
        in_item.op    = rlm_pkg::op_t'(req.cmd);
        in_item.tag   = req.request_tag;
        in_item.now   = req.now_time;
        in_item.bytes = req.byte_count;
        in_item.group = req.group_id;
        in_item.err   = req.error_flag;
    end

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_item    = q_reg[rptr_reg];

    // two entry queue toward the back end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                q_reg[wptr_reg] <= in_item;
                wptr_reg        <= ~wptr_reg;
            end
            if (q_pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

@@ sv/rlm_exec.sv @@
// back end: scans the outstanding and group tables and updates statistics
module rlm_exec
#(
    parameter int PENDING_DEPTH = 256,
    parameter int GROUP_DEPTH   = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  rlm_pkg::item_t       q_item,
    output logic                 q_pop,
    rlm_rsp_if.source            rsp
);

    localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int GW = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
    localparam logic [PW:0]   P_END  = (PW + 1)'(PENDING_DEPTH);
    localparam logic [GW:0]   G_END  = (GW + 1)'(GROUP_DEPTH);
    localparam logic [PW-1:0] P_LAST = PW'(PENDING_DEPTH - 1);
    localparam logic [GW-1:0] G_LAST = GW'(GROUP_DEPTH - 1);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_PSCAN,
        S_PDONE,
        S_GSCAN,
        S_GDONE,
        S_GREAD,
        S_GADD,
        S_OUT
    } state_t;

    state_t                   state_reg;
    rlm_pkg::item_t           item_reg;
    rlm_pkg::result_t         res_reg;
    rlm_pkg::result_t         rsp_reg;
    logic                     rsp_valid_reg;

    // outstanding table
    rlm_pkg::pend_t           pmem [PENDING_DEPTH];
    rlm_pkg::pend_t           prd_reg;
    rlm_pkg::pend_t           phit_data_reg;
    logic [PENDING_DEPTH-1:0] pvalid_reg;
    logic [PW:0]              pcnt_reg;
    logic [PW-1:0]            pidx_reg;
    logic                     pchk_reg;
    logic                     phit_reg;
    logic [PW-1:0]            phit_idx_reg;
    logic                     pfree_reg;
    logic [PW-1:0]            pfree_idx_reg;
    logic                     pwr_en;
    logic [PW-1:0]            pwr_addr;

    // group table
    logic [63:0]              gkey_mem [GROUP_DEPTH];
    rlm_pkg::stats_t          gstat_mem [GROUP_DEPTH];
    logic [63:0]              gkey_rd_reg;
    rlm_pkg::stats_t          gstat_rd_reg;
    logic [GROUP_DEPTH-1:0]   gvalid_reg;
    logic [GW:0]              gcnt_reg;
    logic [GW-1:0]            gidx_reg;
    logic                     gchk_reg;
    logic                     ghit_reg;
    logic [GW-1:0]            ghit_idx_reg;
    logic                     gfree_reg;
    logic [GW-1:0]            gfree_idx_reg;
    logic [GW-1:0]            gslot_reg;
    logic                     gnew_reg;
    rlm_pkg::stats_t          gbase;
    rlm_pkg::stats_t          gsum;

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    // outstanding table write on a stored issue
    assign pwr_en   = (state_reg == S_PDONE) && (item_reg.op == rlm_pkg::OP_ISSUE)
                      && (phit_reg || pfree_reg);
    assign pwr_addr = phit_reg ? phit_idx_reg : pfree_idx_reg;

    // statistics update
    always_comb
    begin
        gbase              = gnew_reg ? '0 : gstat_rd_reg;
        gsum.count         = gbase.count + 64'd1;
        gsum.lat_sum       = gbase.lat_sum + res_reg.latency;
        gsum.byte_sum      = gbase.byte_sum + {32'd0, phit_data_reg.bytes};
        gsum.err_count     = gbase.err_count + {63'd0, item_reg.err};
    end

    // outstanding table memory
    always_ff @(posedge clk)
    begin
        if (pwr_en)
        begin
            pmem[pwr_addr] <= {item_reg.tag, item_reg.now, item_reg.bytes, item_reg.group};
        end
        prd_reg <= pmem[pcnt_reg[PW-1:0]];
    end

    // group key and statistics memories
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_GDONE) && !ghit_reg && gfree_reg)
        begin
            gkey_mem[gfree_idx_reg] <= res_reg.group;
        end
        if (state_reg == S_GADD)
        begin
            gstat_mem[gslot_reg] <= gsum;
        end
        gkey_rd_reg  <= gkey_mem[gcnt_reg[GW-1:0]];
        gstat_rd_reg <= gstat_mem[gslot_reg];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            pvalid_reg    <= '0;
            gvalid_reg    <= '0;
            pchk_reg      <= 1'b0;
            gchk_reg      <= 1'b0;
        end
        else
        begin
            // the output state reloads the result register itself
            if (rsp_valid_reg && rsp.ready && (state_reg != S_OUT))
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg  <= q_item;
                        res_reg   <= '0;
                        pcnt_reg  <= '0;
                        pchk_reg  <= 1'b0;
                        phit_reg  <= 1'b0;
                        pfree_reg <= 1'b0;
                        state_reg <= S_PSCAN;
                    end
                end
                S_PSCAN:
                begin
                    // read one entry per cycle, compare it in the next cycle
                    if (pcnt_reg != P_END)
                    begin
                        pcnt_reg <= pcnt_reg + 1'b1;
                        pidx_reg <= pcnt_reg[PW-1:0];
                        pchk_reg <= 1'b1;
                    end
                    else
                    begin
                        pchk_reg <= 1'b0;
                    end
                    if (pchk_reg)
                    begin
                        if (pvalid_reg[pidx_reg] && (prd_reg.tag == item_reg.tag) && !phit_reg)
                        begin
                            phit_reg      <= 1'b1;
                            phit_idx_reg  <= pidx_reg;
                            phit_data_reg <= prd_reg;
                        end
                        if (!pvalid_reg[pidx_reg] && !pfree_reg)
                        begin
                            pfree_reg     <= 1'b1;
                            pfree_idx_reg <= pidx_reg;
                        end
                        if (pidx_reg == P_LAST)
                        begin
                            state_reg <= S_PDONE;
                        end
                    end
                end
                S_PDONE:
                begin
                    if (item_reg.op == rlm_pkg::OP_ISSUE)
                    begin
                        if (phit_reg || pfree_reg)
                        begin
                            pvalid_reg[pwr_addr] <= 1'b1;
                            res_reg.status       <= rlm_pkg::ST_STORED;
                        end
                        else
                        begin
                            res_reg.status <= rlm_pkg::ST_FULL;
                        end
                        state_reg <= S_OUT;
                    end
                    else if (!phit_reg)
                    begin
                        res_reg.status <= rlm_pkg::ST_UNMATCHED;
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        pvalid_reg[phit_idx_reg] <= 1'b0;
                        res_reg.group   <= phit_data_reg.group;
                        res_reg.latency <= item_reg.now - phit_data_reg.start;
                        gcnt_reg        <= '0;
                        gchk_reg        <= 1'b0;
                        ghit_reg        <= 1'b0;
                        gfree_reg       <= 1'b0;
                        state_reg       <= S_GSCAN;
                    end
                end
                S_GSCAN:
                begin
                    if (gcnt_reg != G_END)
                    begin
                        gcnt_reg <= gcnt_reg + 1'b1;
                        gidx_reg <= gcnt_reg[GW-1:0];
                        gchk_reg <= 1'b1;
                    end
                    else
                    begin
                        gchk_reg <= 1'b0;
                    end
                    if (gchk_reg)
                    begin
                        if (gvalid_reg[gidx_reg] && (gkey_rd_reg == res_reg.group) && !ghit_reg)
                        begin
                            ghit_reg     <= 1'b1;
                            ghit_idx_reg <= gidx_reg;
                        end
                        if (!gvalid_reg[gidx_reg] && !gfree_reg)
                        begin
                            gfree_reg     <= 1'b1;
                            gfree_idx_reg <= gidx_reg;
                        end
                        if (gidx_reg == G_LAST)
                        begin
                            state_reg <= S_GDONE;
                        end
                    end
                end
                S_GDONE:
                begin
                    if (ghit_reg)
                    begin
                        gslot_reg <= ghit_idx_reg;
                        gnew_reg  <= 1'b0;
                        state_reg <= S_GREAD;
                    end
                    else if (gfree_reg)
                    begin
                        gvalid_reg[gfree_idx_reg] <= 1'b1;
                        gslot_reg <= gfree_idx_reg;
                        gnew_reg  <= 1'b1;
                        state_reg <= S_GREAD;
                    end
                    else
                    begin
                        res_reg.status <= rlm_pkg::ST_NOGROUP;
                        state_reg      <= S_OUT;
                    end
                end
                S_GREAD:
                begin
                    state_reg <= S_GADD;
                end
                S_GADD:
                begin
                    res_reg.status <= rlm_pkg::ST_COUNTED;
                    res_reg.stats  <= gsum;
                    state_reg      <= S_OUT;
                end
                S_OUT:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_reg       <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result channel
    assign rsp.valid             = rsp_valid_reg;
    assign rsp.status            = rsp_reg.status;
    assign rsp.stat_group        = rsp_reg.group;
    assign rsp.latency           = rsp_reg.latency;
    assign rsp.group_io_count    = rsp_reg.stats.count;
    assign rsp.group_latency_sum = rsp_reg.stats.lat_sum;
    assign rsp.group_byte_sum    = rsp_reg.stats.byte_sum;
    assign rsp.group_error_count = rsp_reg.stats.err_count;

endmodule

@@ sv/request_latency_monitor.sv @@
// top level of the request latency monitor
//
// Channel req carries issue and completion requests (valid/ready); channel
// rsp returns exactly one result per request, in request order.
// An issue records tag, timestamp, byte count and group in the outstanding
// table; a completion looks up its tag, frees the entry and updates the
// statistics of the request's group, creating the group on first use.
// A two-entry queue sits between the front end and the back end, so the
// front keeps taking requests while the back end works.
// Each request is served by a sequential scan of the tables in memory, one
// entry per cycle: an issue scans the outstanding table, a matched
// completion scans the outstanding table and then the group table. These
// scans set the rate; the back end finishes one request before the next.
// Reset clears the valid bits of both tables at once; no clearing pass runs.
// A stalled rsp holds its result; the back end waits with the next result
// until the current one is taken, and the queue then fills and drops ready.
module request_latency_monitor
#(
    parameter int PENDING_DEPTH = 256,
    parameter int GROUP_DEPTH   = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    rlm_req_if.sink    req,
    rlm_rsp_if.source  rsp
);

    logic           q_valid;
    logic           q_pop;
    rlm_pkg::item_t q_item;

    // request intake and queue
    rlm_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    // table lookup and statistics
    rlm_exec
    #(
        .PENDING_DEPTH (PENDING_DEPTH),
        .GROUP_DEPTH   (GROUP_DEPTH)
    )
    u_exec
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule
